### design/spq_pkg.sv
// shared types and constants for the sorted priority queue
`default_nettype none
package spq_pkg;

	localparam int DEPTH  = 8;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int PRI_W  = 16;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_E_CMP,
		S_E_INS,
		S_D_HEAD,
		S_D_SHIFT
	} state_t;

	typedef enum logic [2:0] {
		RD_ZERO,
		RD_ONE,
		RD_CNT_M1,
		RD_PTR_M2,
		RD_PTR_P1
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_INSERT,
		WR_SHIFT_DOWN,
		WR_SHIFT_UP
	} wr_sel_t;

	typedef struct packed {
		logic [PRI_W-1:0]  pri;
		logic [DATA_W-1:0] data;
	} entry_t;

	typedef struct packed {
		logic    load;
		logic    ptr_load_cnt;
		logic    ptr_load_one;
		logic    ptr_dec;
		logic    ptr_inc;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    head_cap;
		logic    finish;
		status_t fin_status;
		logic    fin_data;
		logic    cnt_inc;
		logic    cnt_dec;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic cnt_gt1;
		logic gt;
		logic ptr_is_one;
		logic at_end;
		logic next_ok;
	} stat_t;

endpackage
`default_nettype wire

### design/spq_ctrl.sv
// controller state machine for the sorted priority queue
`default_nettype none
module spq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          action,
	input  wire spq_pkg::stat_t stat,
	output spq_pkg::cmd_t      cmd,
	output logic               busy
);
	import spq_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (!action) begin
						if (stat.full) begin
							state_next = S_IDLE;
						end else if (stat.empty) begin
							state_next = S_E_INS;
						end else begin
							state_next = S_E_CMP;
						end
					end else begin
						state_next = stat.empty ? S_IDLE : S_D_HEAD;
					end
				end
			end
			S_E_CMP: begin
				if (stat.gt) begin
					state_next = stat.ptr_is_one ? S_E_INS : S_E_CMP;
				end else begin
					state_next = S_IDLE;
				end
			end
			S_E_INS:   state_next = S_IDLE;
			S_D_HEAD:  state_next = S_D_SHIFT;
			S_D_SHIFT: state_next = stat.at_end ? S_IDLE : S_D_SHIFT;
			default:   state_next = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.rd_sel     = RD_ZERO;
		cmd.wr_sel     = WR_INSERT;
		cmd.fin_status = ST_DONE;
		busy           = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (!action) begin
						if (stat.full) begin
							cmd.finish     = 1'b1;
							cmd.fin_status = ST_FULL;
						end else begin
							cmd.ptr_load_cnt = 1'b1;
							if (!stat.empty) begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RD_CNT_M1;
							end
						end
					end else begin
						if (stat.empty) begin
							cmd.finish     = 1'b1;
							cmd.fin_status = ST_EMPTY;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_ZERO;
						end
					end
				end
			end
			S_E_CMP: begin
				cmd.wr_en = 1'b1;
				if (stat.gt) begin
					// move the lower-priority entry one slot down, prefetch the next one
					cmd.wr_sel  = WR_SHIFT_DOWN;
					cmd.ptr_dec = 1'b1;
					if (!stat.ptr_is_one) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_PTR_M2;
					end
				end else begin
					cmd.wr_sel  = WR_INSERT;
					cmd.finish  = 1'b1;
					cmd.cnt_inc = 1'b1;
				end
			end
			S_E_INS: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_INSERT;
				cmd.finish  = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			S_D_HEAD: begin
				cmd.head_cap     = 1'b1;
				cmd.ptr_load_one = 1'b1;
				if (stat.cnt_gt1) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_ONE;
				end
			end
			S_D_SHIFT: begin
				if (stat.at_end) begin
					cmd.finish   = 1'b1;
					cmd.fin_data = 1'b1;
					cmd.cnt_dec  = 1'b1;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wr_sel  = WR_SHIFT_UP;
					cmd.ptr_inc = 1'b1;
					if (stat.next_ok) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_PTR_P1;
					end
				end
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

### design/spq_dp.sv
// datapath for the sorted priority queue: entry memory, pointer, count, result registers
`default_nettype none
module spq_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire spq_pkg::cmd_t                cmd,
	input  wire logic [spq_pkg::DATA_W-1:0]   item_data,
	input  wire logic [spq_pkg::PRI_W-1:0]    item_priority,
	output spq_pkg::stat_t                    stat,
	output logic                              done,
	output spq_pkg::status_t                  status,
	output logic [spq_pkg::DATA_W-1:0]        out_data,
	output logic                              now_empty,
	output logic                              now_full
);
	import spq_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_q;
	entry_t item_q;
	logic [DATA_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  count_next;
	logic [CNT_W-1:0]  cnt_m1;
	logic [CNT_W-1:0]  ptr_m1;
	logic [CNT_W-1:0]  ptr_m2;
	logic [CNT_W-1:0]  ptr_p1;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_entry;

	logic              done_q;
	status_t           status_q;
	logic [DATA_W-1:0] out_data_q;
	logic              now_empty_q;
	logic              now_full_q;

	assign cnt_m1 = count_q - CNT_W'(1);
	assign ptr_m1 = ptr_q - CNT_W'(1);
	assign ptr_m2 = ptr_q - CNT_W'(2);
	assign ptr_p1 = ptr_q + CNT_W'(1);

	always_comb begin
		stat.full       = (count_q == CNT_W'(DEPTH));
		stat.empty      = (count_q == '0);
		stat.cnt_gt1    = (count_q > CNT_W'(1));
		stat.gt         = (item_q.pri > rd_q.pri);
		stat.ptr_is_one = (ptr_q == CNT_W'(1));
		stat.at_end     = (ptr_q == count_q);
		stat.next_ok    = (ptr_p1 < count_q);
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_ZERO:   rd_addr = '0;
			RD_ONE:    rd_addr = IDX_W'(1);
			RD_CNT_M1: rd_addr = cnt_m1[IDX_W-1:0];
			RD_PTR_M2: rd_addr = ptr_m2[IDX_W-1:0];
			RD_PTR_P1: rd_addr = ptr_p1[IDX_W-1:0];
			default:   rd_addr = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			WR_INSERT: begin
				wr_addr  = ptr_q[IDX_W-1:0];
				wr_entry = item_q;
			end
			WR_SHIFT_DOWN: begin
				wr_addr  = ptr_q[IDX_W-1:0];
				wr_entry = rd_q;
			end
			WR_SHIFT_UP: begin
				wr_addr  = ptr_m1[IDX_W-1:0];
				wr_entry = rd_q;
			end
			default: begin
				wr_addr  = ptr_q[IDX_W-1:0];
				wr_entry = item_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q.pri  <= item_priority;
			item_q.data <= item_data;
		end
		if (cmd.head_cap) begin
			head_q <= rd_q.data;
		end
	end

	always_comb begin
		count_next = count_q;
		priority if (cmd.cnt_inc) begin
			count_next = count_q + CNT_W'(1);
		end else if (cmd.cnt_dec) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ptr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= cmd.finish;
			priority if (cmd.ptr_load_cnt) begin
				ptr_q <= count_q;
			end else if (cmd.ptr_load_one) begin
				ptr_q <= CNT_W'(1);
			end else if (cmd.ptr_dec) begin
				ptr_q <= ptr_m1;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_p1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q    <= cmd.fin_status;
			out_data_q  <= cmd.fin_data ? head_q : '0;
			now_empty_q <= (count_next == '0);
			now_full_q  <= (count_next == CNT_W'(DEPTH));
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign out_data  = out_data_q;
	assign now_empty = now_empty_q;
	assign now_full  = now_full_q;

endmodule
`default_nettype wire

### design/sorted_priority_queue.sv
// top level of the sorted priority queue: controller plus datapath
// enqueue: start loads the item, then each entry of lower priority moves one slot down before the insert;
// dequeue: the head is captured, then every later entry moves up one slot; rejects finish straight from idle
// busy is low again in the cycle done shows, so the next start is taken at its closing edge
// the rate is set by the walk over the entry memory, one read and one write a cycle
// arst_n clears the entry count, pointer, state and done strobe; memory contents stay unknown
`default_nettype none
module sorted_priority_queue (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              action,
	input  wire logic signed [spq_pkg::DATA_W-1:0] item_data,
	input  wire logic [spq_pkg::PRI_W-1:0]         item_priority,
	output logic                                   done,
	output logic [1:0]                             status,
	output logic signed [spq_pkg::DATA_W-1:0]      out_data,
	output logic                                   now_empty,
	output logic                                   now_full
);
	import spq_pkg::*;

	cmd_t              cmd;
	stat_t             stat;
	status_t           status_w;
	logic [DATA_W-1:0] out_data_w;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	spq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.item_data     (item_data),
		.item_priority (item_priority),
		.stat          (stat),
		.done          (done),
		.status        (status_w),
		.out_data      (out_data_w),
		.now_empty     (now_empty),
		.now_full      (now_full)
	);

	assign status   = status_w;
	assign out_data = out_data_w;

endmodule
`default_nettype wire

### design/spq_checker.sv
// port-level checks for the sorted priority queue, bound to the top level
`default_nettype none
module spq_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              busy,
	input wire logic                              done,
	input wire logic [1:0]                        status,
	input wire logic signed [spq_pkg::DATA_W-1:0] out_data,
	input wire logic                              now_empty,
	input wire logic                              now_full
);
	import spq_pkg::*;

	// a transaction result never shows while a walk is still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(now_empty && now_full))
		else $error("queue reported empty and full at once");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> now_full)
		else $error("full reject without full flag");

	a_empty_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> now_empty)
		else $error("empty reject without empty flag");

	a_reject_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DONE) |-> (out_data == '0))
		else $error("rejected transaction returned data");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);
`default_nettype wire

### verif/tb_top.sv
// self-checking testbench for the sorted priority queue: directed edge cases, then random traffic
`default_nettype none
module tb_top;
	import spq_pkg::*;

	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;
	localparam int   CYCLE_LIMIT = 400000;
	localparam int   DRAIN_CYCLES = 16;

	typedef struct {
		logic signed [DATA_W-1:0] data;
		logic [PRI_W-1:0]         pri;
	} held_entry_t;

	typedef struct {
		status_t                  st;
		logic signed [DATA_W-1:0] data;
		logic                     empty;
		logic                     full;
	} outcome_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     action;
	logic signed [DATA_W-1:0] item_data;
	logic [PRI_W-1:0]         item_priority;
	logic                     done;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] out_data;
	logic                     now_empty;
	logic                     now_full;

	held_entry_t held_q[$];
	outcome_t    pending_q[$];
	outcome_t    want;
	int          errors = 0;
	int          cycle_cnt = 0;
	int          idle_pct = 0;

	sorted_priority_queue i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.item_data     (item_data),
		.item_priority (item_priority),
		.done          (done),
		.status        (status),
		.out_data      (out_data),
		.now_empty     (now_empty),
		.now_full      (now_full)
	);

	always #10 clk = ~clk;

	// queue contents kept sorted, highest priority at the front, ties in arrival order
	function automatic outcome_t queue_apply(input logic op, input logic signed [DATA_W-1:0] d,
			input logic [PRI_W-1:0] p);
		outcome_t    r;
		held_entry_t e;
		int          pos;
		r.st = ST_DONE;
		r.data = '0;
		if (op == OP_ENQUEUE) begin
			if (held_q.size() >= DEPTH) begin
				r.st = ST_FULL;
			end else begin
				e.data = d;
				e.pri = p;
				pos = held_q.size();
				while (pos > 0 && p > held_q[pos-1].pri)
					pos--;
				held_q.insert(pos, e);
			end
		end else begin
			if (held_q.size() == 0) begin
				r.st = ST_EMPTY;
			end else begin
				e = held_q.pop_front();
				r.data = e.data;
			end
		end
		r.empty = (held_q.size() == 0);
		r.full = (held_q.size() == DEPTH);
		return r;
	endfunction

	// called at a rising edge; returns once taken; start stays high unless an idle gap follows
	task automatic send_item(input logic op, input logic signed [DATA_W-1:0] d,
			input logic [PRI_W-1:0] p);
		start <= 1'b1;
		action <= op;
		item_data <= d;
		item_priority <= p;
		do @(posedge clk); while (busy);
		pending_q.push_back(queue_apply(op, d, p));
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	function automatic logic [PRI_W-1:0] rand_priority();
		case ($urandom_range(3))
			0: return PRI_W'($urandom_range(3));
			1: return PRI_W'(16'hFFFF - $urandom_range(3));
			default: return PRI_W'($urandom);
		endcase
	endfunction

	task automatic test_empty_dequeue();
		send_item(OP_DEQUEUE, 32'sh1234_5678, 16'hFFFF);
	endtask

	// extremes of data and priority, ties at the middle and at the top, then a rejected enqueue
	task automatic test_order_and_full();
		send_item(OP_ENQUEUE, 32'sh8000_0000, 16'h0000);
		send_item(OP_ENQUEUE, 32'sh7FFF_FFFF, 16'hFFFF);
		send_item(OP_ENQUEUE, -32'sd1, 16'h8000);
		send_item(OP_ENQUEUE, 32'sd0, 16'h8000);
		send_item(OP_ENQUEUE, 32'sh5555_5555, 16'h8000);
		send_item(OP_ENQUEUE, 32'sh0000_0001, 16'h0001);
		send_item(OP_ENQUEUE, 32'shAAAA_AAAA, 16'hFFFF);
		send_item(OP_ENQUEUE, 32'sh0F0F_0F0F, 16'hFFFE);
		send_item(OP_ENQUEUE, 32'sh7FFF_FFFF, 16'hFFFF);
	endtask

	task automatic test_drain();
		repeat (DEPTH) send_item(OP_DEQUEUE, 32'sh0, 16'h0);
		send_item(OP_DEQUEUE, -32'sd1, 16'h0000);
	endtask

	// bursts that lean to filling, to draining or to neither, so the queue swings between full and empty
	task automatic test_random_traffic(input int n_items);
		int left;
		int burst;
		int enq_pct;
		int mode;
		left = n_items;
		while (left > 0) begin
			burst = $urandom_range(4, 20);
			mode = $urandom_range(2);
			enq_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
			for (int k = 0; k < burst && left > 0; k++) begin
				send_item(($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE,
					$urandom, rand_priority());
				left--;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected transaction: status %0d data %0d empty %0b full %0b",
					$time, status, out_data, now_empty, now_full);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					errors++;
				end
				if (out_data !== want.data) begin
					$display("%0t: out_data expected %0d actual %0d", $time, want.data, out_data);
					errors++;
				end
				if (now_empty !== want.empty) begin
					$display("%0t: now_empty expected %0b actual %0b", $time, want.empty,
						now_empty);
					errors++;
				end
				if (now_full !== want.full) begin
					$display("%0t: now_full expected %0b actual %0b", $time, want.full, now_full);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[sorted_priority_queue] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		action = OP_ENQUEUE;
		item_data = '0;
		item_priority = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 0;
		test_empty_dequeue();
		test_order_and_full();
		test_drain();

		idle_pct = 0;
		test_random_traffic(640);
		idle_pct = 71;
		test_random_traffic(640);
		idle_pct = 21;
		test_random_traffic(640);

		start <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[sorted_priority_queue] OK");
		else
			$display("[sorted_priority_queue] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
